// ----- rtl/stable_matching_engine_defines.svh -----
`ifndef STABLE_MATCHING_ENGINE_DEFINES_SVH
`define STABLE_MATCHING_ENGINE_DEFINES_SVH

// same-cycle implication, reset masked
`define SME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sme_pkg.sv -----
package sme_pkg;

    localparam int MAX_N        = 16;
    localparam int IDX_W        = $clog2(MAX_N);
    localparam int CNT_W        = IDX_W + 1;
    localparam int PAIR_COUNT_W = 5;
    localparam int OP_W         = 2;
    localparam int FIELD_W      = 4;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 8;

    localparam logic [OP_W-1:0] OP_LOAD_PREF = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RANK = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN       = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

endpackage

// ----- rtl/stable_matching_engine.sv -----
// Channel   Dir  tdata (low bit up)                 tuser   tlast
// s_axis    in   person[3:0] position[7:4]          op      -
//                partner[11:8], zero pad to 16
// m_axis    out  acceptor[3:0] proposer[7:4]        -       last pair
// cfg       in   i_cfg_wdata = pair_count (5 bits), written when i_cfg_we
//
// Loads are written straight into the tables; ready stays high in idle.
// A run does a setup step, then per queue pop: an exhausted list drops the proposer;
// a refused or free-acceptor proposal needs only the preference read, and a contest also
// reads the rank memory twice (single read port); at most n*n proposals; then n pairs out.
// Ready is low from a run transaction until the last pair is taken; output stalls hold.
// Reset clears control, engagements and the queue; the preference and rank memories are not.
module stable_matching_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sme_pkg::PAIR_COUNT_W-1:0] i_cfg_wdata,   // pair_count
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sme_pkg::IN_DATA_W-1:0]  s_axis_tdata,    // person, position, partner
    input  logic [sme_pkg::OP_W-1:0]       s_axis_tuser,    // op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sme_pkg::OUT_DATA_W-1:0] m_axis_tdata,    // acceptor, proposer
    output logic                           m_axis_tlast     // last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POP    = 3'd1;
    localparam logic [2:0] S_PREF   = 3'd2;
    localparam logic [2:0] S_RANK   = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam int MEM_AW = 2 * sme_pkg::IDX_W;
    localparam int MEM_D  = sme_pkg::MAX_N * sme_pkg::MAX_N;

    logic [2:0]                         r_state;
    logic [sme_pkg::PAIR_COUNT_W-1:0]   r_pair_count;
    sme_pkg::t_cnt                      w_n;

    sme_pkg::t_cnt                      r_next_choice [sme_pkg::MAX_N];
    logic [sme_pkg::MAX_N-1:0]          r_eng_valid;
    sme_pkg::t_idx                      r_eng_id      [sme_pkg::MAX_N];
    sme_pkg::t_idx                      r_fifo        [sme_pkg::MAX_N];
    sme_pkg::t_idx                      r_head;
    sme_pkg::t_idx                      r_tail;
    sme_pkg::t_cnt                      r_count;

    sme_pkg::t_idx                      r_prop;
    sme_pkg::t_idx                      r_acc;
    sme_pkg::t_idx                      r_cur;
    logic [sme_pkg::FIELD_W-1:0]        r_rank_new;
    sme_pkg::t_idx                      r_idx;

    logic [sme_pkg::FIELD_W-1:0]        r_pref_mem [MEM_D];
    logic [sme_pkg::FIELD_W-1:0]        r_rank_mem [MEM_D];
    logic [sme_pkg::FIELD_W-1:0]        r_pref_q;
    logic [sme_pkg::FIELD_W-1:0]        r_rank_q;

    logic                               w_in_hs;
    logic [sme_pkg::OP_W-1:0]           w_op;
    sme_pkg::t_idx                      w_person;
    sme_pkg::t_idx                      w_position;
    sme_pkg::t_idx                      w_partner;
    logic                               w_pref_we;
    logic                               w_rank_we;
    logic [MEM_AW-1:0]                  w_pref_raddr;
    logic [MEM_AW-1:0]                  w_rank_raddr;
    sme_pkg::t_idx                      w_head_p;
    sme_pkg::t_idx                      w_a;
    logic                               w_out_last;

    always_comb begin
        if (r_pair_count == '0) begin
            w_n = sme_pkg::t_cnt'(1);
        end else if (sme_pkg::CNT_W'(r_pair_count) > sme_pkg::t_cnt'(sme_pkg::MAX_N)) begin
            w_n = sme_pkg::t_cnt'(sme_pkg::MAX_N);
        end else begin
            w_n = sme_pkg::CNT_W'(r_pair_count);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_hs       = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_person      = s_axis_tdata[3:0];
    assign w_position    = s_axis_tdata[7:4];
    assign w_partner     = s_axis_tdata[11:8];
    assign w_pref_we     = w_in_hs && (w_op == sme_pkg::OP_LOAD_PREF);
    assign w_rank_we     = w_in_hs && (w_op == sme_pkg::OP_LOAD_RANK);

    assign w_head_p      = r_fifo[r_head];
    assign w_a           = r_pref_q;
    assign w_pref_raddr  = {w_head_p, r_next_choice[w_head_p][sme_pkg::IDX_W-1:0]};
    assign w_rank_raddr  = (r_state == S_PREF) ? {w_a, r_prop} : {r_acc, r_cur};

    // preference and rank tables, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_pref_we) begin
            r_pref_mem[{w_person, w_position}] <= w_partner;
        end
        r_pref_q <= r_pref_mem[w_pref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rank_we) begin
            r_rank_mem[{w_person, w_partner}] <= w_position;
        end
        r_rank_q <= r_rank_mem[w_rank_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pair_count <= sme_pkg::PAIR_COUNT_W'(sme_pkg::MAX_N);
            r_eng_valid  <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            for (int i = 0; i < sme_pkg::MAX_N; i++) begin
                r_next_choice[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_pair_count <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_hs && (w_op == sme_pkg::OP_RUN)) begin
                        for (int i = 0; i < sme_pkg::MAX_N; i++) begin
                            r_next_choice[i] <= '0;
                            r_fifo[i]        <= sme_pkg::IDX_W'(i);
                        end
                        r_eng_valid <= '0;
                        r_head      <= '0;
                        r_tail      <= w_n[sme_pkg::IDX_W-1:0];
                        r_count     <= w_n;
                        r_state     <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_count == '0) begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_head  <= r_head + 1'b1;
                        r_count <= r_count - 1'b1;
                        r_prop  <= w_head_p;
                        if (r_next_choice[w_head_p] < w_n) begin
                            r_next_choice[w_head_p] <= r_next_choice[w_head_p] + 1'b1;
                            r_state <= S_PREF;
                        end
                    end
                end
                S_PREF: begin
                    r_acc <= w_a;
                    r_cur <= r_eng_id[w_a];
                    if (sme_pkg::CNT_W'(w_a) >= w_n) begin
                        r_fifo[r_tail] <= r_prop;
                        r_tail         <= r_tail + 1'b1;
                        r_count        <= r_count + 1'b1;
                        r_state        <= S_POP;
                    end else if (!r_eng_valid[w_a]) begin
                        r_eng_valid[w_a] <= 1'b1;
                        r_eng_id[w_a]    <= r_prop;
                        r_state          <= S_POP;
                    end else begin
                        r_state <= S_RANK;
                    end
                end
                S_RANK: begin
                    r_rank_new <= r_rank_q;
                    r_state    <= S_CMP;
                end
                S_CMP: begin
                    // ties keep the current partner
                    if (r_rank_new < r_rank_q) begin
                        r_fifo[r_tail]  <= r_cur;
                        r_eng_id[r_acc] <= r_prop;
                    end else begin
                        r_fifo[r_tail]  <= r_prop;
                    end
                    r_tail  <= r_tail + 1'b1;
                    r_count <= r_count + 1'b1;
                    r_state <= S_POP;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_idx <= r_idx + 1'b1;
                        if (w_out_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_out_last    = ((sme_pkg::CNT_W'(r_idx) + 1'b1) == w_n);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = w_out_last;
    assign m_axis_tdata  = {(r_eng_valid[r_idx] ? r_eng_id[r_idx] : sme_pkg::t_idx'(0)), r_idx};

endmodule

// ----- rtl/sme_checker.sv -----
`include "stable_matching_engine_defines.svh"

module sme_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [sme_pkg::OP_W-1:0]       s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sme_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    logic w_out_hs;
    assign w_out_hs = m_axis_tvalid && m_axis_tready;

    `SME_ASSERT_NOW(a_out_hold, $past(i_rst_n) && $past(m_axis_tvalid && !m_axis_tready), m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled pair changed")

    `SME_ASSERT_NOW(a_busy_during_out, m_axis_tvalid, !s_axis_tready, "input ready while pairs pending")

    `SME_ASSERT_NEXT(a_last_ends_run, w_out_hs && m_axis_tlast, !m_axis_tvalid && s_axis_tready, "run did not end after last pair")

    `SME_ASSERT_NEXT(a_acceptor_steps, w_out_hs && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1), "acceptor order broken")

    `SME_ASSERT_NEXT(a_load_no_output, s_axis_tvalid && s_axis_tready && (s_axis_tuser != sme_pkg::OP_RUN), !m_axis_tvalid, "load produced a pair")

endmodule

bind stable_matching_engine sme_checker u_sme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    sme_pkg::t_idx acceptor;
    sme_pkg::t_idx proposer;
    logic          last;
} t_match_pair;

class match_scoreboard;
    logic [sme_pkg::PAIR_COUNT_W-1:0] pair_count;
    sme_pkg::t_idx pref_list [sme_pkg::MAX_N][sme_pkg::MAX_N];
    sme_pkg::t_idx rank_of   [sme_pkg::MAX_N][sme_pkg::MAX_N];
    t_match_pair   pending_pairs[$];
    int            failures;

    function new();
        pair_count = 5'd16;
        failures   = 0;
        foreach (pref_list[i, j]) begin
            pref_list[i][j] = '0;
            rank_of[i][j]   = '0;
        end
    endfunction

    function void write_pair_count(logic [sme_pkg::PAIR_COUNT_W-1:0] value);
        pair_count = value;
    endfunction

    function int pairs_in_use();
        if (pair_count == 0) return 1;
        if (pair_count > sme_pkg::MAX_N) return sme_pkg::MAX_N;
        return int'(pair_count);
    endfunction

    function int outstanding();
        return pending_pairs.size();
    endfunction

    // one accepted input transaction
    function void note_item(logic [sme_pkg::OP_W-1:0] op, sme_pkg::t_idx person,
                            sme_pkg::t_idx position, sme_pkg::t_idx partner);
        case (op)
            sme_pkg::OP_LOAD_PREF: pref_list[person][position] = partner;
            sme_pkg::OP_LOAD_RANK: rank_of[person][partner] = position;
            sme_pkg::OP_RUN:       resolve_matching();
            default: ;
        endcase
    endfunction

    function void resolve_matching();
        int          n;
        int          p;
        int          a;
        int          cur;
        int          next_pos   [sme_pkg::MAX_N];
        int          partner_of [sme_pkg::MAX_N];
        int          free_q[$];
        t_match_pair pr;
        n = pairs_in_use();
        foreach (next_pos[i]) begin
            next_pos[i]   = 0;
            partner_of[i] = -1;
        end
        for (int i = 0; i < n; i++) free_q.push_back(i);
        while (free_q.size() != 0) begin
            p = free_q.pop_front();
            if (next_pos[p] < n) begin
                a = int'(pref_list[p][next_pos[p]]);
                next_pos[p]++;
                if (a >= n) begin
                    free_q.push_back(p);
                end else if (partner_of[a] < 0) begin
                    partner_of[a] = p;
                end else begin
                    cur = partner_of[a];
                    // ties keep the current partner
                    if (rank_of[a][p] < rank_of[a][cur]) begin
                        free_q.push_back(cur);
                        partner_of[a] = p;
                    end else begin
                        free_q.push_back(p);
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            pr.acceptor = sme_pkg::t_idx'(i);
            pr.proposer = (partner_of[i] < 0) ? '0 : sme_pkg::t_idx'(partner_of[i]);
            pr.last     = (i == n - 1);
            pending_pairs.push_back(pr);
        end
    endfunction

    function void check_pair(sme_pkg::t_idx acceptor, sme_pkg::t_idx proposer, logic last);
        t_match_pair want;
        if (pending_pairs.size() == 0) begin
            failures++;
            $display("%0t: unexpected pair, expected none, got acceptor %0d proposer %0d last %0b",
                     $time, acceptor, proposer, last);
            return;
        end
        want = pending_pairs.pop_front();
        if (acceptor !== want.acceptor) begin
            failures++;
            $display("%0t: acceptor mismatch, expected %0d, got %0d",
                     $time, want.acceptor, acceptor);
        end
        if (proposer !== want.proposer) begin
            failures++;
            $display("%0t: proposer mismatch on acceptor %0d, expected %0d, got %0d",
                     $time, want.acceptor, want.proposer, proposer);
        end
        if (last !== want.last) begin
            failures++;
            $display("%0t: last mismatch on acceptor %0d, expected %0b, got %0b",
                     $time, want.acceptor, want.last, last);
        end
    endfunction
endclass

module tb_top;
    import sme_pkg::*;

    localparam int                RESET_CYCLES  = 8;
    localparam int                SETTLE_CYCLES = 6;
    localparam int                HOLD_CYCLES   = 400;
    localparam int                STALL_LIMIT   = 6000;
    localparam int                RANDOM_ITEMS  = 60;
    localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_idx            person;
        t_idx            position;
        t_idx            partner;
    } t_stim_item;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [PAIR_COUNT_W-1:0] i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;     // person, position, partner, zero pad
    logic [OP_W-1:0]         s_axis_tuser;     // op
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;     // acceptor, proposer
    logic                    m_axis_tlast;

    match_scoreboard sb;
    int              src_idle_pct;
    int              dst_idle_pct;
    int              hold_asked;
    int              hold_served;
    int              stall_cycles;
    int              items_sent;

    stable_matching_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_pair_count(i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4],
                             s_axis_tdata[11:8]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_pair(m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random back-pressure, or a long hold when asked
    initial begin
        m_axis_tready = 1'b0;
        hold_served   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_asked) begin
                m_axis_tready <= 1'b0;
                for (int k = 1; k < HOLD_CYCLES; k++) @(negedge i_clk);
                hold_served++;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input t_idx person,
                             input t_idx position, input t_idx partner);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, partner, position, person};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op != OP_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_pairs();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_pair_count(input logic [PAIR_COUNT_W-1:0] value);
        drain_pairs();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic void draw_permutation(input int n, ref int order[$]);
        int j;
        int tmp;
        order.delete();
        for (int i = 0; i < n; i++) order.push_back(i);
        for (int k = n - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
    endfunction

    // ignored op, or a load to rows outside the active region
    function automatic t_stim_item noise_item(input int n);
        t_stim_item it;
        it.person   = t_idx'($urandom_range(15));
        it.position = t_idx'($urandom_range(15));
        it.partner  = t_idx'($urandom_range(15));
        if (n < MAX_N && $urandom_range(1) == 0) begin
            it.op     = $urandom_range(1) ? OP_LOAD_RANK : OP_LOAD_PREF;
            it.person = t_idx'($urandom_range(15, n));
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic play_matching_set(input logic [PAIR_COUNT_W-1:0] count_value,
                                     input bit well_formed, input int noise,
                                     input bit pressure);
        int         n;
        int         order[$];
        int         load_order[$];
        t_stim_item loads[$];
        t_stim_item it;
        apply_pair_count(count_value);
        n = (count_value == 0) ? 1 : ((count_value > MAX_N) ? MAX_N : int'(count_value));
        for (int p = 0; p < n; p++) begin
            draw_permutation(n, order);
            for (int pos = 0; pos < n; pos++) begin
                it.op       = OP_LOAD_PREF;
                it.person   = t_idx'(p);
                it.position = t_idx'(pos);
                it.partner  = well_formed ? t_idx'(order[pos]) : t_idx'($urandom_range(15));
                loads.push_back(it);
            end
        end
        for (int a = 0; a < n; a++) begin
            draw_permutation(n, order);
            for (int p = 0; p < n; p++) begin
                it.op       = OP_LOAD_RANK;
                it.person   = t_idx'(a);
                it.position = well_formed ? t_idx'(order[p]) : t_idx'($urandom_range(15));
                it.partner  = t_idx'(p);
                loads.push_back(it);
            end
        end
        repeat (noise) loads.push_back(noise_item(n));
        draw_permutation(loads.size(), load_order);
        foreach (load_order[i]) begin
            it = loads[load_order[i]];
            send_item(it.op, it.person, it.position, it.partner);
        end
        if (pressure) hold_asked++;
        send_item(OP_RUN, t_idx'($urandom_range(15)), t_idx'($urandom_range(15)),
                  t_idx'($urandom_range(15)));
        if ($urandom_range(3) == 0) begin
            send_item(OP_RUN, t_idx'($urandom_range(15)), t_idx'($urandom_range(15)),
                      t_idx'($urandom_range(15)));
        end
        if (pressure) begin
            repeat (8) begin
                it = noise_item(n);
                send_item(it.op, it.person, it.position, it.partner);
            end
        end
    endtask

    initial begin
        int                      target;
        logic [PAIR_COUNT_W-1:0] count_value;
        int                      pick;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD_PREF;
        src_idle_pct  = 32;
        dst_idle_pct  = 73;
        hold_asked    = 0;
        stall_cycles  = 0;
        items_sent    = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single pair
        apply_pair_count(5'd1);
        send_item(OP_UNUSED, 4'd15, 4'd15, 4'd15);
        send_item(OP_LOAD_PREF, 4'd0, 4'd0, 4'd0);
        send_item(OP_LOAD_RANK, 4'd0, 4'd0, 4'd0);
        send_item(OP_RUN, 4'd0, 4'd0, 4'd0);
        // zero counts as one
        apply_pair_count(5'd0);
        send_item(OP_RUN, 4'd15, 4'd15, 4'd15);

        // refused choice, exhausted list, tied ranks, unmatched acceptor
        apply_pair_count(5'd2);
        send_item(OP_LOAD_PREF, 4'd0, 4'd0, 4'd3);
        send_item(OP_LOAD_PREF, 4'd0, 4'd1, 4'd0);
        send_item(OP_LOAD_PREF, 4'd1, 4'd0, 4'd0);
        send_item(OP_LOAD_PREF, 4'd1, 4'd1, 4'd0);
        send_item(OP_LOAD_RANK, 4'd0, 4'd1, 4'd0);
        send_item(OP_LOAD_RANK, 4'd0, 4'd1, 4'd1);
        send_item(OP_LOAD_RANK, 4'd1, 4'd0, 4'd0);
        send_item(OP_LOAD_RANK, 4'd1, 4'd15, 4'd1);
        send_item(OP_UNUSED, 4'd0, 4'd0, 4'd0);
        send_item(OP_RUN, 4'd0, 4'd0, 4'd0);
        send_item(OP_RUN, 4'd5, 4'd10, 4'd3);

        for (int phase = 0; phase < 3; phase++) begin
            drain_pairs();
            src_idle_pct = (phase == 0) ? 32 : ((phase == 1) ? 73 : 0);
            dst_idle_pct = (phase == 0) ? 73 : ((phase == 1) ? 32 : 0);
            target       = items_sent + RANDOM_ITEMS / 3;
            if (phase == 2) play_matching_set(5'd4, 1'b1, 2, 1'b1);
            while (items_sent < target) begin
                pick = $urandom_range(9);
                if (pick == 0) count_value = PAIR_COUNT_W'($urandom_range(1));
                else if (pick == 1) count_value = PAIR_COUNT_W'($urandom_range(8, 6));
                else count_value = PAIR_COUNT_W'($urandom_range(5, 2));
                play_matching_set(count_value, $urandom_range(3) != 0, $urandom_range(4), 1'b0);
            end
        end

        // full size, then an oversized count on the same tables
        play_matching_set(5'd16, 1'b1, 3, 1'b0);
        apply_pair_count(5'd31);
        send_item(OP_RUN, 4'd0, 4'd0, 4'd0);

        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
